// ----- rtl/fdmc_pkg.sv -----
// Shared types, constants and codes for the fuzzy DNA match counter.
package fdmc_pkg;

   localparam int MAX_PATTERN = 64;
   localparam int COUNT_WIDTH = 24;
   localparam int PLEN_W      = $clog2(MAX_PATTERN + 1);
   localparam int IDX_W       = (MAX_PATTERN > 1) ? $clog2(MAX_PATTERN) : 1;
   localparam int POS_W       = 24;
   localparam int DIST_W      = 17;
   localparam int TOL_W       = 16;
   localparam int OUT_W       = 24;
   localparam int NUM_SYM     = 4;
   localparam int CSR_ADDR_W  = 3;
   localparam int CSR_DATA_W  = 32;

   typedef enum logic [1:0] {
      KIND_PATTERN = 2'd0,
      KIND_TEXT    = 2'd1,
      KIND_END     = 2'd2
   } kind_type;

   typedef enum logic [0:0] {
      REG_TOLERANCE = 1'b0
   } reg_index_type;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_FLUSH,
      ST_RESP
   } state_type;

   typedef struct packed {
      logic pat_write;
      logic text_step;
      logic flush_step;
      logic finish;
   } cmd_type;

   typedef struct packed {
      logic flush_done;
   } status_type;

endpackage

// ----- rtl/fdmc_ctrl.sv -----
// Controller state machine: decodes items and sequences the end-of-text flush.
module fdmc_ctrl
   import fdmc_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  logic [1:0] req_kind,
   output logic       req_ready,
   output logic       rsp_valid,
   input  logic       rsp_ready,
   input  status_type status,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   always_comb begin
      state_in  = state_ff;
      cmd       = '0;
      req_ready = 1'b0;
      rsp_valid = 1'b0;
      case (state_ff)
         ST_IDLE: begin
            req_ready = 1'b1;
            if (req_valid) begin
               case (kind_type'(req_kind))
                  KIND_PATTERN: cmd.pat_write = 1'b1;
                  KIND_TEXT:    cmd.text_step = 1'b1;
                  KIND_END:     state_in = ST_FLUSH;
                  default:      ;
               endcase
            end
         end
         ST_FLUSH: begin
            // Complete one pending position a cycle until the head catches up.
            if (status.flush_done) begin
               cmd.finish = 1'b1;
               state_in   = ST_RESP;
            end else begin
               cmd.flush_step = 1'b1;
            end
         end
         ST_RESP: begin
            rsp_valid = 1'b1;
            if (rsp_ready) begin
               state_in = ST_IDLE;
            end
         end
         default: state_in = ST_IDLE;
      endcase
   end

   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      !(req_ready && rsp_valid))
      else $error("input taken while a result is pending");

   a_end_starts_flush: assert property (@(posedge clock) disable iff (reset)
      (req_ready && req_valid && req_kind == KIND_END) |=> state_ff == ST_FLUSH)
      else $error("end of text did not start the flush");

   a_finish_gives_result: assert property (@(posedge clock) disable iff (reset)
      cmd.finish |=> rsp_valid)
      else $error("finished flush did not present a result");

endmodule

// ----- rtl/fdmc_datapath.sv -----
// Datapath: pattern masks, symbol distances, shift-and vector and counters.
module fdmc_datapath
   import fdmc_pkg::*;
(
   input  logic              clock,
   input  logic              reset,
   input  cmd_type           cmd,
   input  logic [1:0]        symbol,
   input  logic [TOL_W-1:0]  tolerance,
   output status_type        status,
   output logic [OUT_W-1:0]  match_count
);

   logic [MAX_PATTERN-1:0] mask_ff [NUM_SYM];
   logic [MAX_PATTERN-1:0] mask_in [NUM_SYM];
   logic [DIST_W-1:0]      dist_ff [NUM_SYM];
   logic [DIST_W-1:0]      dist_in [NUM_SYM];
   logic [MAX_PATTERN-1:0] mv_ff, mv_in, mv_next, near_mask;
   logic [PLEN_W-1:0]      plen_ff, plen_in, last_idx;
   logic [POS_W-1:0]       head_ff, head_in, tlen_ff, tlen_in;
   logic [COUNT_WIDTH-1:0] count_ff, count_in;
   logic [OUT_W-1:0]       out_ff, out_in;
   logic [OUT_W+COUNT_WIDTH-1:0] count_ext;
   logic [DIST_W-1:0]      span;
   logic                   complete, hit;

   assign span      = {1'b0, tolerance} << 1;
   assign last_idx  = plen_ff - PLEN_W'(1);
   assign count_ext = {{OUT_W{1'b0}}, count_ff};
   assign status.flush_done = (head_ff >= tlen_ff);
   assign match_count = out_ff;

   always_comb begin
      for (int c = 0; c < NUM_SYM; c++) begin
         mask_in[c] = mask_ff[c];
         dist_in[c] = dist_ff[c];
      end
      plen_in  = plen_ff;
      mv_in    = mv_ff;
      head_in  = head_ff;
      tlen_in  = tlen_ff;
      count_in = count_ff;
      out_in   = out_ff;
      complete = 1'b0;

      if (cmd.pat_write && (plen_ff < PLEN_W'(MAX_PATTERN))) begin
         mask_in[symbol][plen_ff[IDX_W-1:0]] = 1'b1;
         plen_in = plen_ff + PLEN_W'(1);
      end

      if (cmd.text_step || cmd.flush_step) begin
         for (int c = 0; c < NUM_SYM; c++) begin
            if (!(&dist_ff[c])) begin
               dist_in[c] = dist_ff[c] + DIST_W'(1);
            end
         end
      end
      if (cmd.text_step) begin
         dist_in[symbol] = '0;
         if (!(&tlen_ff)) begin
            tlen_in = tlen_ff + POS_W'(1);
         end
         // A position is complete once tolerance further symbols have arrived.
         complete = (tlen_ff >= POS_W'(tolerance));
      end
      if (cmd.flush_step) begin
         complete = 1'b1;
      end

      near_mask = '0;
      for (int c = 0; c < NUM_SYM; c++) begin
         if (dist_in[c] <= span) begin
            near_mask = near_mask | mask_ff[c];
         end
      end
      mv_next = ((mv_ff << 1) | MAX_PATTERN'(1)) & near_mask;
      hit = (plen_ff == '0) ? 1'b1 : mv_next[last_idx[IDX_W-1:0]];

      if (complete) begin
         mv_in = mv_next;
         if (hit && !(&count_ff)) begin
            count_in = count_ff + COUNT_WIDTH'(1);
         end
         if (!(&head_ff)) begin
            head_in = head_ff + POS_W'(1);
         end
      end

      if (cmd.finish) begin
         out_in = count_ext[OUT_W-1:0];
         for (int c = 0; c < NUM_SYM; c++) begin
            dist_in[c] = '1;
         end
         mv_in    = '0;
         head_in  = '0;
         tlen_in  = '0;
         count_in = '0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int c = 0; c < NUM_SYM; c++) begin
            mask_ff[c] <= '0;
            dist_ff[c] <= '1;
         end
         plen_ff  <= '0;
         mv_ff    <= '0;
         head_ff  <= '0;
         tlen_ff  <= '0;
         count_ff <= '0;
      end else begin
         for (int c = 0; c < NUM_SYM; c++) begin
            mask_ff[c] <= mask_in[c];
            dist_ff[c] <= dist_in[c];
         end
         plen_ff  <= plen_in;
         mv_ff    <= mv_in;
         head_ff  <= head_in;
         tlen_ff  <= tlen_in;
         count_ff <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      out_ff <= out_in;
   end

   a_head_behind_text: assert property (@(posedge clock) disable iff (reset)
      head_ff <= tlen_ff)
      else $error("completed positions ran ahead of received text");

endmodule

// ----- rtl/fuzzy_dna_match_counter_top.sv -----
// Top level of the fuzzy DNA match counter: register port and module wiring.
//
// Pattern symbols and text symbols are taken directly in the idle state. An
// end-of-text item starts the flush sequence, which completes one pending
// text position a cycle through the shift-and datapath (at most min(tolerance,
// text length) positions are pending) and then finishes. The count then
// sits in the output register until its transfer, and the next input item is
// taken in the cycle after. Tolerance lives at byte address 0.
module fuzzy_dna_match_counter_top
   import fdmc_pkg::*;
(
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_ready,
   input  logic [1:0]            req_kind,
   input  logic [1:0]            req_symbol,
   output logic                  rsp_valid,
   input  logic                  rsp_ready,
   output logic [OUT_W-1:0]      rsp_match_count,
   input  logic                  psel,
   input  logic                  penable,
   input  logic                  pwrite,
   input  logic [CSR_ADDR_W-1:0] paddr,
   input  logic [CSR_DATA_W-1:0] pwdata,
   output logic [CSR_DATA_W-1:0] prdata,
   output logic                  pready
);

   logic [TOL_W-1:0] tol_ff, tol_in;
   logic             reg_hit;
   cmd_type          cmd;
   status_type       status;

   assign pready  = 1'b1;
   assign reg_hit = (reg_index_type'(paddr[CSR_ADDR_W-1]) == REG_TOLERANCE);
   assign prdata  = reg_hit ? {{(CSR_DATA_W - TOL_W){1'b0}}, tol_ff} : '0;

   always_comb begin
      tol_in = tol_ff;
      if (psel && penable && pwrite && pready && reg_hit) begin
         tol_in = pwdata[TOL_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         tol_ff <= '0;
      end else begin
         tol_ff <= tol_in;
      end
   end

   fdmc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_kind  (req_kind),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   fdmc_datapath u_datapath (
      .clock       (clock),
      .reset       (reset),
      .cmd         (cmd),
      .symbol      (req_symbol),
      .tolerance   (tol_ff),
      .status      (status),
      .match_count (rsp_match_count)
   );

endmodule
